// ----- rtl/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

  // Default sizes
  localparam int unsigned DEF_CAPACITY       = 16;
  localparam int unsigned DEF_PAYLOAD_WIDTH  = 32;
  localparam int unsigned DEF_PRIORITY_WIDTH = 16;

  // Request kinds
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY_DEQ = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCENDING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST   = 2'd2;

  // Operation broadcast to every cell at once
  typedef struct packed {
    logic enq;        // committed insert
    logic deq;        // committed removal of the head
    logic ascending;  // smaller priority goes first
  } spq_op_t;

endpackage

`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned CELL_IDX       = 0,
  parameter int unsigned CNT_W          = 5,
  parameter int unsigned PAYLOAD_WIDTH  = DEF_PAYLOAD_WIDTH,
  parameter int unsigned PRIORITY_WIDTH = DEF_PRIORITY_WIDTH
) (
  input  wire                              clk,
  input  wire spq_op_t                     op,
  input  wire [CNT_W-1:0]                  count,
  input  wire signed [PRIORITY_WIDTH-1:0]  new_pri,
  input  wire [PAYLOAD_WIDTH-1:0]          new_pay,
  input  wire signed [PRIORITY_WIDTH-1:0]  left_pri,
  input  wire [PAYLOAD_WIDTH-1:0]          left_pay,
  input  wire signed [PRIORITY_WIDTH-1:0]  right_pri,
  input  wire [PAYLOAD_WIDTH-1:0]          right_pay,
  input  wire                              found_in,
  output logic                             found_out,
  output logic signed [PRIORITY_WIDTH-1:0] pri,
  output logic [PAYLOAD_WIDTH-1:0]         pay
);

  logic signed [PRIORITY_WIDTH-1:0] pri_r;
  logic [PAYLOAD_WIDTH-1:0]         pay_r;
  logic                             occupied;
  logic                             at_tail;
  logic                             precedes;
  logic                             here;

  // Slot holds a live entry when it sits below the fill level
  assign occupied = CNT_W'(CELL_IDX) < count;
  assign at_tail  = count == CNT_W'(CELL_IDX);

  // New entry strictly ahead of this one under the current order
  assign precedes = op.ascending ? (new_pri < pri_r) : (new_pri > pri_r);
  assign here     = occupied && precedes;

  // Insertion point already found upstream or right here
  assign found_out = found_in | here;

  // Insert: cells past the insertion point take the left neighbor's word,
  // the insertion cell (or first free one) takes the new word.
  // Remove: every cell takes its right neighbor's word; the last cell keeps its own.
  always_ff @(posedge clk) begin
    if (op.enq) begin
      if (found_in) begin
        pri_r <= left_pri;
        pay_r <= left_pay;
      end else if (here || at_tail) begin
        pri_r <= new_pri;
        pay_r <= new_pay;
      end
    end else if (op.deq) begin
      pri_r <= right_pri;
      pay_r <= right_pay;
    end
  end

  assign pri = pri_r;
  assign pay = pay_r;

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue built as a chain of CAPACITY compare-and-shift cells.
// The result word is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle; the chain shifts by one slot per word,
// so only a stalled result word holds off the next request.
// Reset (rst_n low, synchronous): count cleared, output empty, configuration
// back to ascending order and the full signed priority range.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY       = DEF_CAPACITY,
  parameter int unsigned PAYLOAD_WIDTH  = DEF_PAYLOAD_WIDTH,
  parameter int unsigned PRIORITY_WIDTH = DEF_PRIORITY_WIDTH,
  localparam int unsigned CNT_W         = $clog2(CAPACITY + 1)
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // request channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_action,
  input  wire [PAYLOAD_WIDTH-1:0]          in_payload,
  input  wire signed [PRIORITY_WIDTH-1:0]  in_priority_req,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [STATUS_W-1:0]              out_status,
  output logic [PAYLOAD_WIDTH-1:0]         out_taken_payload,
  output logic                             out_taken_valid,
  output logic [PAYLOAD_WIDTH-1:0]         out_head_payload,
  output logic signed [PRIORITY_WIDTH-1:0] out_head_priority,
  output logic [CNT_W-1:0]                 out_entry_count,
  output logic                             out_is_empty,
  // configuration
  input  wire                              cfg_we,
  input  wire [CFG_IDX_W-1:0]              cfg_index,
  input  wire [PRIORITY_WIDTH-1:0]         cfg_data
);

  logic                             ascending_r;
  logic signed [PRIORITY_WIDTH-1:0] lowest_r;
  logic signed [PRIORITY_WIDTH-1:0] highest_r;

  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]              status_r, status_nxt;
  logic [PAYLOAD_WIDTH-1:0]         taken_r, taken_nxt;
  logic                             taken_valid_r, taken_valid_nxt;

  logic                             accept;
  logic                             in_range;
  logic                             full;
  logic                             enq_ok;
  logic                             deq_ok;
  spq_op_t                          op;

  logic signed [PRIORITY_WIDTH-1:0] cell_pri [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0]         cell_pay [CAPACITY];
  logic [CAPACITY-1:0]              found;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascending_r <= 1'b1;
      lowest_r    <= {1'b1, {(PRIORITY_WIDTH-1){1'b0}}};
      highest_r   <= {1'b0, {(PRIORITY_WIDTH-1){1'b1}}};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ASCENDING: ascending_r <= cfg_data[0];
        CFG_LOWEST:    lowest_r    <= cfg_data;
        CFG_HIGHEST:   highest_r   <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Handshake: stall only while a result waits and is itself stalled
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Request decode
  assign in_range = !(in_priority_req < lowest_r) && !(in_priority_req > highest_r);
  assign full     = count_r == CNT_W'(CAPACITY);
  assign enq_ok   = accept && (in_action == ACT_ENQ) && in_range && !full;
  assign deq_ok   = accept && (in_action == ACT_DEQ) && (count_r != '0);

  assign op.enq       = enq_ok;
  assign op.deq       = deq_ok;
  assign op.ascending = ascending_r;

  // Status, fill level and result word
  always_comb begin
    status_nxt      = ST_OK;
    taken_nxt       = '0;
    taken_valid_nxt = 1'b0;
    count_nxt       = count_r;
    if (in_action == ACT_ENQ) begin
      if (!in_range) begin
        status_nxt = ST_RANGE;
      end else if (full) begin
        status_nxt = ST_FULL;
      end
    end else if (count_r == '0) begin
      status_nxt = ST_EMPTY_DEQ;
    end else begin
      taken_nxt       = cell_pay[0];
      taken_valid_nxt = 1'b1;
    end
    if (enq_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      taken_r       <= taken_nxt;
      taken_valid_r <= taken_valid_nxt;
    end
  end

  // Cell chain: slot 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [PRIORITY_WIDTH-1:0] l_pri, r_pri;
    logic [PAYLOAD_WIDTH-1:0]         l_pay, r_pay;
    logic                             f_in;

    if (i == 0) begin : g_first
      assign l_pri = in_priority_req;
      assign l_pay = in_payload;
      assign f_in  = 1'b0;
    end else begin : g_mid
      assign l_pri = cell_pri[i-1];
      assign l_pay = cell_pay[i-1];
      assign f_in  = found[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_pri = cell_pri[i];
      assign r_pay = cell_pay[i];
    end else begin : g_inner
      assign r_pri = cell_pri[i+1];
      assign r_pay = cell_pay[i+1];
    end

    spq_cell #(
      .CELL_IDX       (i),
      .CNT_W          (CNT_W),
      .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .count     (count_r),
      .new_pri   (in_priority_req),
      .new_pay   (in_payload),
      .left_pri  (l_pri),
      .left_pay  (l_pay),
      .right_pri (r_pri),
      .right_pay (r_pay),
      .found_in  (f_in),
      .found_out (found[i]),
      .pri       (cell_pri[i]),
      .pay       (cell_pay[i])
    );
  end

  // Head view comes live from slot 0; queue contents only move on an accepted word,
  // and that word always replaces the result word.
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_taken_payload = taken_r;
  assign out_taken_valid   = taken_valid_r;
  assign out_entry_count   = count_r;
  assign out_is_empty      = count_r == '0;
  assign out_head_payload  = (count_r != '0) ? cell_pay[0] : '0;
  assign out_head_priority = (count_r != '0) ? cell_pri[0] : '0;

endmodule

`default_nettype wire

// ----- rtl/spq_checker.sv -----
`default_nettype none

module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY       = DEF_CAPACITY,
  parameter int unsigned PAYLOAD_WIDTH  = DEF_PAYLOAD_WIDTH,
  parameter int unsigned PRIORITY_WIDTH = DEF_PRIORITY_WIDTH,
  localparam int unsigned CNT_W         = $clog2(CAPACITY + 1)
) (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire [STATUS_W-1:0]              out_status,
  input wire [PAYLOAD_WIDTH-1:0]         out_taken_payload,
  input wire                             out_taken_valid,
  input wire [PAYLOAD_WIDTH-1:0]         out_head_payload,
  input wire signed [PRIORITY_WIDTH-1:0] out_head_priority,
  input wire [CNT_W-1:0]                 out_entry_count,
  input wire                             out_is_empty
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_taken_payload) && $stable(out_entry_count))
    else $error("result word changed while stalled");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_empty == (out_entry_count == '0))
    else $error("empty flag disagrees with entry count");

  // Count never exceeds the store size
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A removed word only comes with an ok status; otherwise it reads zero
  a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_taken_valid && out_status == ST_OK)
      || (!out_taken_valid && out_taken_payload == '0))
    else $error("taken word inconsistent with status");

  // Empty store shows a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_head_payload == '0 && out_head_priority == '0)
    else $error("nonzero head on empty store");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY       (CAPACITY),
  .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
  .PRIORITY_WIDTH (PRIORITY_WIDTH)
) u_spq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_taken_payload (out_taken_payload),
  .out_taken_valid   (out_taken_valid),
  .out_head_payload  (out_head_payload),
  .out_head_priority (out_head_priority),
  .out_entry_count   (out_entry_count),
  .out_is_empty      (out_is_empty)
);

`default_nettype wire

// ----- sim/sorted_priority_queue_test.sv -----
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned CAP     = DEF_CAPACITY;
  localparam int unsigned PAY_W   = DEF_PAYLOAD_WIDTH;
  localparam int unsigned PRI_W   = DEF_PRIORITY_WIDTH;
  localparam int unsigned COUNT_W = $clog2(DEF_CAPACITY + 1);
  localparam int          PRI_MIN = -32768;
  localparam int          PRI_MAX = 32767;
  localparam int unsigned RANDOM_WORDS = 950;
  localparam int unsigned HOLD_CYCLES  = 90;

  // one result word as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [PAY_W-1:0]        taken_payload;
    logic                    taken_valid;
    logic [PAY_W-1:0]        head_payload;
    logic signed [PRI_W-1:0] head_priority;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_empty;
  } result_word_t;

  // Shadow of the sorted store plus the queue of results still to come
  class queue_scoreboard;
    logic signed [PRI_W-1:0] slot_pri [CAP];
    logic [PAY_W-1:0]        slot_pay [CAP];
    int unsigned             stored;
    bit                      ascending;
    logic signed [PRI_W-1:0] lowest;
    logic signed [PRI_W-1:0] highest;
    result_word_t            awaited_words [$];
    int unsigned             mismatches;
    int unsigned             words_checked;
    int unsigned             status_seen [4];

    function new();
      stored = 0;
      ascending = 1'b1;
      lowest = 16'sh8000;
      highest = 16'sh7fff;
      mismatches = 0;
      words_checked = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PRI_W-1:0] data);
      case (idx)
        CFG_ASCENDING: ascending = data[0];
        CFG_LOWEST:    lowest = data;
        CFG_HIGHEST:   highest = data;
        default: ;
      endcase
    endfunction

    // a strictly precedes b under the current service order
    function bit served_first(logic signed [PRI_W-1:0] a, logic signed [PRI_W-1:0] b);
      return ascending ? (a < b) : (a > b);
    endfunction

    // apply one accepted request and queue the word it must produce
    function void note_request(logic action, logic [PAY_W-1:0] pay,
                               logic signed [PRI_W-1:0] pri);
      result_word_t r;
      int pos;
      int i;
      r = '0;
      r.status = ST_OK;
      if (action == ACT_ENQ) begin
        if (pri < lowest || pri > highest) begin
          r.status = ST_RANGE;
        end else if (stored >= CAP) begin
          r.status = ST_FULL;
        end else begin
          // no re-sort on mode change: head compared first, then scan from slot 1
          pos = 0;
          if (stored != 0 && !served_first(pri, slot_pri[0])) begin
            pos = 1;
            while (pos < int'(stored) && !served_first(pri, slot_pri[pos])) pos++;
          end
          for (i = int'(stored); i > pos; i--) begin
            slot_pri[i] = slot_pri[i-1];
            slot_pay[i] = slot_pay[i-1];
          end
          slot_pri[pos] = pri;
          slot_pay[pos] = pay;
          stored++;
        end
      end else begin
        if (stored == 0) begin
          r.status = ST_EMPTY_DEQ;
        end else begin
          r.taken_payload = slot_pay[0];
          r.taken_valid = 1'b1;
          for (i = 1; i < int'(stored); i++) begin
            slot_pri[i-1] = slot_pri[i];
            slot_pay[i-1] = slot_pay[i];
          end
          stored--;
        end
      end
      r.head_payload  = (stored != 0) ? slot_pay[0] : '0;
      r.head_priority = (stored != 0) ? slot_pri[0] : '0;
      r.entry_count   = COUNT_W'(stored);
      r.is_empty      = (stored == 0);
      awaited_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_word(result_word_t got);
      result_word_t want;
      if (awaited_words.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, got %h", $time, got);
        return;
      end
      want = awaited_words.pop_front();
      words_checked++;
      status_seen[want.status]++;
      compare_field("status", want.status, got.status);
      compare_field("taken_payload", want.taken_payload, got.taken_payload);
      compare_field("taken_valid", want.taken_valid, got.taken_valid);
      compare_field("head_payload", want.head_payload, got.head_payload);
      compare_field("head_priority", want.head_priority, got.head_priority);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("is_empty", want.is_empty, got.is_empty);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_action = ACT_ENQ;
  logic [PAY_W-1:0]         in_payload = '0;
  logic signed [PRI_W-1:0]  in_priority_req = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic [PAY_W-1:0]         out_taken_payload;
  logic                     out_taken_valid;
  logic [PAY_W-1:0]         out_head_payload;
  logic signed [PRI_W-1:0]  out_head_priority;
  logic [COUNT_W-1:0]       out_entry_count;
  logic                     out_is_empty;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_ASCENDING;
  logic [PRI_W-1:0]         cfg_data = '0;

  queue_scoreboard sb = new();
  bit              long_hold_req = 1'b0;
  int unsigned     phases_run = 0;

  sorted_priority_queue uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_payload        (in_payload),
    .in_priority_req   (in_priority_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_taken_payload (out_taken_payload),
    .out_taken_valid   (out_taken_valid),
    .out_head_payload  (out_head_payload),
    .out_head_priority (out_head_priority),
    .out_entry_count   (out_entry_count),
    .out_is_empty      (out_is_empty),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor: register writes, accepted requests, accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_request(in_action, in_payload, in_priority_req);
      if (out_valid && !out_stall)
        sb.check_word('{out_status, out_taken_payload, out_taken_valid, out_head_payload,
                        out_head_priority, out_entry_count, out_is_empty});
    end
  end

  // Receiver: stall pattern changes every span; a long hold when asked
  initial begin
    int unsigned mode;
    int unsigned span_left;
    int unsigned hold_left;
    int unsigned tick;
    mode = 0;
    span_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (span_left == 0) begin
        mode = $urandom_range(0, 3);
        span_left = $urandom_range(10, 60);
      end
      span_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 25);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= (tick % 4 != 0);
        endcase
      end
    end
  end

  // offer one request word and hold it until the block takes it
  task automatic send_word(logic action, logic [PAY_W-1:0] pay, logic [PRI_W-1:0] pri);
    in_valid <= 1'b1;
    in_action <= action;
    in_payload <= pay;
    in_priority_req <= pri;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop offering and wait until every expected word has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg_word(logic [CFG_IDX_W-1:0] idx, logic [PRI_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // mode word carries random upper bits; only bit 0 matters
  task automatic set_config(bit asc, int lo, int hi);
    write_reg_word(CFG_ASCENDING, {15'($urandom), asc});
    write_reg_word(CFG_LOWEST, PRI_W'(lo));
    write_reg_word(CFG_HIGHEST, PRI_W'(hi));
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  // mostly in range with frequent ties, plus bounds, extremes and noise
  function automatic logic [PRI_W-1:0] pick_priority(int lo, int hi);
    int pick;
    int span;
    pick = $urandom_range(0, 9);
    span = hi - lo;
    if (pick <= 5 && span >= 0) begin
      if (pick <= 1) return PRI_W'(lo + $urandom_range(0, (span < 3) ? span : 3));
      return PRI_W'(lo + int'($urandom_range(0, span)));
    end
    case (pick)
      6: begin
        case ($urandom_range(0, 3))
          0: return PRI_W'(lo);
          1: return PRI_W'(hi);
          2: return PRI_W'(lo - 1);
          default: return PRI_W'(hi + 1);
        endcase
      end
      7: return $urandom_range(0, 1) ? PRI_W'(PRI_MIN) : PRI_W'(PRI_MAX);
      default: return PRI_W'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned words_sent;
    int unsigned phase_len;
    int unsigned burst_left;
    int unsigned style;
    int unsigned enq_pct;
    int          lo;
    int          hi;
    bit          asc;
    bit          gapless;
    logic        action;
    int          k;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty dequeue, extremes and ties, fill past full
    send_word(ACT_DEQ, '1, '1);
    send_word(ACT_ENQ, 32'hffff_ffff, 16'h7fff);
    send_word(ACT_ENQ, 32'h0000_0000, 16'h8000);
    send_word(ACT_ENQ, 32'h1234_5678, 16'h0000);
    send_word(ACT_ENQ, 32'ha5a5_a5a5, 16'h0000);
    send_word(ACT_ENQ, 32'h5a5a_5a5a, 16'hffff);
    send_word(ACT_ENQ, 32'h0000_0001, 16'h8000);
    for (k = 0; k < 11; k++) send_word(ACT_ENQ, 32'hc000_0000 | k, PRI_W'(k * 3 - 10));

    // descending order, narrow range, store still full and unsorted for it
    wait_for_drain();
    set_config(1'b0, -10, 10);
    send_word(ACT_ENQ, 32'hdead_beef, 16'd100);
    send_word(ACT_ENQ, 32'hbeef_dead, 16'd5);
    send_word(ACT_DEQ, '0, '0);
    send_word(ACT_DEQ, '0, '0);
    send_word(ACT_ENQ, 32'h0bad_f00d, 16'd10);
    send_word(ACT_ENQ, 32'hf00d_0bad, 16'hfff5);
    send_word(ACT_ENQ, 32'h3333_3333, 16'd3);

    // inverted range rejects everything
    wait_for_drain();
    set_config(1'b1, 5, -5);
    send_word(ACT_ENQ, 32'h7777_7777, 16'd0);

    // random phases, each under its own setting
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      wait_for_drain();
      asc = $urandom_range(0, 1);
      case ($urandom_range(0, 7))
        0: begin lo = PRI_MIN; hi = PRI_MAX; asc = 1'b1; end
        1: begin lo = PRI_MIN; hi = PRI_MAX; asc = 1'b0; end
        2: begin lo = -int'($urandom_range(0, 200)); hi = $urandom_range(0, 200); end
        3: begin lo = $urandom_range(1, 3000); hi = lo - int'($urandom_range(1, 3000)); end
        4: begin lo = int'($urandom_range(0, 65535)) - 32768; hi = lo; end
        5: begin lo = PRI_MIN; hi = int'($urandom_range(0, 65535)) - 32768; end
        6: begin lo = int'($urandom_range(0, 65535)) - 32768; hi = PRI_MAX; end
        default: begin
          lo = int'($urandom_range(0, 65535)) - 32768;
          hi = int'($urandom_range(0, 65535)) - 32768;
        end
      endcase
      set_config(asc, lo, hi);

      style = $urandom_range(0, 2);
      enq_pct = (style == 0) ? 75 : (style == 1) ? 30 : 55;
      phase_len = $urandom_range(20, 70);
      gapless = ($urandom_range(0, 3) == 0);
      // long output hold while requests keep coming, so the block backs up
      if (phases_run == 6 || phases_run == 15) begin
        long_hold_req = 1'b1;
        gapless = 1'b1;
        enq_pct = 80;
      end
      burst_left = $urandom_range(1, 16);
      repeat (phase_len) begin
        action = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
        send_word(action, $urandom, pick_priority(lo, hi));
        words_sent++;
        if (!gapless) begin
          burst_left--;
          if (burst_left == 0) begin
            pause_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
          end
        end
      end
    end

    wait_for_drain();
    repeat (5) @(posedge clk);
    $display("%0d result words checked: %0d ok, %0d out of range, %0d full, %0d empty dequeue",
             sb.words_checked, sb.status_seen[ST_OK], sb.status_seen[ST_RANGE],
             sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY_DEQ]);
    $display("%0d settings applied, both service orders, narrow, inverted and single ranges",
             phases_run);
    if (sb.mismatches == 0 && sb.awaited_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("timeout with %0d result words outstanding", sb.awaited_words.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
